>>> design/rhr_pkg.sv
// Package with the beat types and the default constant of the hue recolour core.
`timescale 1ns / 1ps
package rhr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [15:0] new_hue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [16:0] src_hue;
    logic [16:0] src_saturation;
    logic [16:0] src_lightness;
  } pix_out_t;

endpackage

>>> design/rgb_hsl_hue_recolor_core.sv
// Top level of the RGB to HSL hue recolour core.
// Throughput: one beat per cycle; busy is never raised, and the depth is set by
// the two chained one-bit-per-stage dividers (source HSL, then rebuild ratio).
// Reset clears only the valid bits of the pipeline; results cannot be stalled.
`timescale 1ns / 1ps
module rgb_hsl_hue_recolor_core #(
  parameter int unsigned FRAC_BITS = rhr_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rhr_pkg::pix_in_t in_i,
  output logic             done_o,
  output rhr_pkg::pix_out_t res_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned LW = F + 1;
  localparam logic [F+1:0] ONE  = (F+2)'(1) << F;
  localparam logic [F+1:0] HALF = ONE >> 1;
  localparam int unsigned SW2 = 5 * LW + 16;

  assign busy = 1'b0;

  // Input register.
  logic             v0_q;
  rhr_pkg::pix_in_t px0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    px0_q <= in_i;
  end

  // Extremes, hue numerator and divisors.
  logic [7:0]         r, g, b, mx, mn, d, sden;
  logic [8:0]         sum;
  logic [10:0]        d6;
  logic signed [11:0] nraw;
  logic               dz;

  always_comb begin
    r = px0_q.in_red;
    g = px0_q.in_green;
    b = px0_q.in_blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    d6  = ({3'b0, d} << 2) + ({3'b0, d} << 1);
    dz  = (d == 8'd0);
    if (r == mx) begin
      nraw = $signed({4'b0, g}) - $signed({4'b0, b});
    end else if (g == mx) begin
      nraw = $signed({3'b0, d, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
    end else begin
      nraw = $signed({2'b0, d, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
    end
    if (nraw < 0) nraw = nraw + $signed({1'b0, d6});
    if (sum < 9'd255) sden = sum[7:0];
    else              sden = 8'(9'd510 - sum);
    if (dz) sden = 8'd1;
  end

  logic        v1_q, dz1_q;
  logic [7:0]  d1_q, sden1_q;
  logic [8:0]  sum1_q;
  logic [10:0] num1_q, d61_q;
  logic [15:0] nh1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dz1_q   <= dz;
    d1_q    <= d;
    sden1_q <= sden;
    sum1_q  <= sum;
    num1_q  <= nraw[10:0];
    d61_q   <= dz ? 11'd1 : d6;
    nh1_q   <= px0_q.new_hue;
  end

  // Lightness is sum/510. The remainder of sum/255 divided by 255 is that byte
  // repeated as a binary fraction, so its truncation is exact.
  logic [1:0]    lt1;
  logic [7:0]    lr1;
  logic [31:0]   lrep1;
  logic [LW-1:0] l1;

  always_comb begin
    if (sum1_q >= 9'd510)      lt1 = 2'd2;
    else if (sum1_q >= 9'd255) lt1 = 2'd1;
    else                       lt1 = 2'd0;
    lr1   = 8'(sum1_q - 9'(lt1) * 9'd255);
    lrep1 = {4{lr1}};
    l1    = (LW'(lt1) << (F - 1)) + LW'(lrep1[31:33-F]);
  end

  // Source saturation and hue dividers run side by side; lightness rides along.
  logic          vl;
  logic [LW-1:0] ql, qs, qh;
  logic [15:0]   nhl;
  logic          dzl;

  rhr_div #(.NW(8 + F), .DW(8), .QW(LW), .SW(17 + LW)) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   ({d1_q, {F{1'b0}}}),
    .den_i   (sden1_q),
    .side_i  ({nh1_q, dz1_q, l1}),
    .valid_o (vl),
    .quo_o   (qs),
    .side_o  ({nhl, dzl, ql})
  );

  rhr_div #(.NW(11 + F), .DW(11), .QW(LW), .SW(1)) u_div_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   ({num1_q, {F{1'b0}}}),
    .den_i   (d61_q),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (qh),
    .side_o  ()
  );

  // Products for the rebuild value term.
  logic [LW-1:0]    l2_q, s2_q, h2_q;
  logic [15:0]      nh2_q;
  logic [2*F+2:0]   pa2_q;
  logic [2*F+1:0]   pb2_q;
  logic             v2_q;
  logic [LW-1:0]    s_src, h_src;

  assign s_src = dzl ? '0 : qs;
  assign h_src = dzl ? '0 : qh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= vl;
    end
  end

  always_ff @(posedge clk_i) begin
    l2_q  <= ql;
    s2_q  <= s_src;
    h2_q  <= h_src;
    nh2_q <= nhl;
    pa2_q <= ql * (ONE + {1'b0, s_src});
    pb2_q <= ql * s_src;
  end

  // Value and minimum terms.
  logic [F+2:0] vw;
  logic [F+2:0] l2x;
  logic [LW-1:0] vv, mm;

  always_comb begin
    if ({1'b0, l2_q} <= HALF) begin
      vw = pa2_q[2*F+2:F];
    end else begin
      vw = {2'b0, l2_q} + {2'b0, s2_q} - (F+3)'(pb2_q[2*F+1:F]);
    end
    vv  = vw[LW-1:0];
    l2x = {1'b0, l2_q, 1'b0};
    if (l2x < vw) mm = '0;
    else          mm = LW'(l2x - vw);
  end

  logic          v3_q;
  logic [LW-1:0] vv3_q, mm3_q, l3_q, s3_q, h3_q;
  logic [15:0]   nh3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vv3_q <= vv;
    mm3_q <= mm;
    l3_q  <= l2_q;
    s3_q  <= s2_q;
    h3_q  <= h2_q;
    nh3_q <= nh2_q;
  end

  // Ratio of the value span to the value.
  logic          v4;
  logic [LW-1:0] sv4, vv4, mm4, l4, s4, h4;
  logic [15:0]   nh4;
  logic [LW-1:0] span3, den3;

  assign span3 = vv3_q - mm3_q;
  assign den3  = (vv3_q == '0) ? LW'(1) : vv3_q;

  rhr_div #(.NW(2 * F + 1), .DW(LW), .QW(LW), .SW(SW2)) u_div_sv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   ({span3, {F{1'b0}}}),
    .den_i   (den3),
    .side_i  ({vv3_q, mm3_q, l3_q, s3_q, h3_q, nh3_q}),
    .valid_o (v4),
    .quo_o   (sv4),
    .side_o  ({vv4, mm4, l4, s4, h4, nh4})
  );

  // Replacement hue at the internal scale, then sextant and fraction.
  logic [F-1:0] hn;
  logic [F+2:0] h6;

  if (F <= 16) begin : g_hn_narrow
    assign hn = nh4[15:16-F];
  end else begin : g_hn_wide
    assign hn = {nh4, {(F-16){1'b0}}};
  end

  assign h6 = ({3'b0, hn} << 2) + ({3'b0, hn} << 1);

  logic           v5_q;
  logic [2*F+1:0] p5_q;
  logic [2:0]     sx5_q;
  logic [F-1:0]   fr5_q;
  logic [LW-1:0]  vv5_q, mm5_q, l5_q, s5_q, h5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_q  <= vv4 * sv4;
    sx5_q <= h6[F+2:F];
    fr5_q <= h6[F-1:0];
    vv5_q <= vv4;
    mm5_q <= mm4;
    l5_q  <= l4;
    s5_q  <= s4;
    h5_q  <= h4;
  end

  logic          v6_q;
  logic [2*F:0]  p6_q;
  logic [2:0]    sx6_q;
  logic [LW-1:0] vv6_q, mm6_q, l6_q, s6_q, h6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p6_q  <= p5_q[2*F:F] * fr5_q;
    sx6_q <= sx5_q;
    vv6_q <= vv5_q;
    mm6_q <= mm5_q;
    l6_q  <= l5_q;
    s6_q  <= s5_q;
    h6_q  <= h5_q;
  end

  // Sextant selection and byte scaling.
  logic [LW-1:0] vsf;
  logic [F+1:0]  mid1, mid2, vx, mx6, ro, go, bo;

  assign vsf  = p6_q[2*F:F];
  assign vx   = {1'b0, vv6_q};
  assign mx6  = {1'b0, mm6_q};
  assign mid1 = mx6 + {1'b0, vsf};
  assign mid2 = vx - {1'b0, vsf};

  always_comb begin
    ro = {1'b0, l6_q};
    go = {1'b0, l6_q};
    bo = {1'b0, l6_q};
    if (vv6_q != '0) begin
      case (sx6_q)
        3'd0:    begin ro = vx;   go = mid1; bo = mx6;  end
        3'd1:    begin ro = mid2; go = vx;   bo = mx6;  end
        3'd2:    begin ro = mx6;  go = vx;   bo = mid1; end
        3'd3:    begin ro = mx6;  go = mid2; bo = vx;   end
        3'd4:    begin ro = mid1; go = mx6;  bo = vx;   end
        default: begin ro = vx;   go = mx6;  bo = mid2; end
      endcase
    end
  end

  function automatic logic [7:0] to_byte(input logic [F+1:0] c);
    logic [F+1:0] cc;
    logic [F+9:0] p;
    cc = (c > ONE) ? ONE : c;
    p  = ({8'b0, cc} << 8) - {8'b0, cc};
    return p[F+7:F];
  endfunction

  logic [16:0] hq, sq, lq;

  if (F < 16) begin : g_q16_up
    assign hq = {h6_q, {(16-F){1'b0}}};
    assign sq = {s6_q, {(16-F){1'b0}}};
    assign lq = {l6_q, {(16-F){1'b0}}};
  end else if (F == 16) begin : g_q16_same
    assign hq = h6_q;
    assign sq = s6_q;
    assign lq = l6_q;
  end else begin : g_q16_down
    assign hq = h6_q[F:F-16];
    assign sq = s6_q[F:F-16];
    assign lq = l6_q[F:F-16];
  end

  logic              done_q;
  rhr_pkg::pix_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.out_red        <= to_byte(ro);
    res_q.out_green      <= to_byte(go);
    res_q.out_blue       <= to_byte(bo);
    res_q.src_hue        <= hq;
    res_q.src_saturation <= sq;
    res_q.src_lightness  <= lq;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> design/rhr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module rhr_div #(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 9,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [QW];
  logic [NW-1:0] num_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          prev_vld;
    logic [NW-1:0] prev_num;
    logic [DW-1:0] prev_den;
    logic [DW-1:0] prev_rem;
    logic [QW-1:0] prev_quo;
    logic [SW-1:0] prev_side;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      // The top bits of the numerator are known to be below the divisor.
      assign prev_vld  = valid_i;
      assign prev_num  = num_i;
      assign prev_den  = den_i;
      assign prev_rem  = DW'(num_i[NW-1:QW]);
      assign prev_quo  = '0;
      assign prev_side = side_i;
    end else begin : g_next
      assign prev_vld  = vld_q[k-1];
      assign prev_num  = num_q[k-1];
      assign prev_den  = den_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_quo  = quo_q[k-1];
      assign prev_side = side_q[k-1];
    end

    assign trial = {prev_rem, prev_num[QW-1-k]};
    assign ge    = trial >= {1'b0, prev_den};
    assign diff  = trial - {1'b0, prev_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= prev_num;
      den_q[k]  <= prev_den;
      rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q[k]  <= {prev_quo[QW-2:0], ge};
      side_q[k] <= prev_side;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

>>> dv/tb_rgb_hsl_hue_recolor_core.sv
// Testbench for the hue recolour core: random and edge pixels checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_rgb_hsl_hue_recolor_core;

  localparam int FB = rhr_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 2 * FB + 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint ONE_FX = longint'(1) << FB;
  localparam longint HALF_FX = longint'(1) << (FB - 1);

  class pixel_scoreboard;
    rhr_pkg::pix_out_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    static function longint to_byte(longint c);
      longint b;
      if (c < 0) c = 0;
      if (c > ONE_FX) c = ONE_FX;
      b = (c * 255) >>> FB;
      if (b > 255) b = 255;
      return b;
    endfunction

    static function logic [16:0] to_q16(longint x);
      return 17'(((x << 16) >>> FB) & 'h1FFFF);
    endfunction

    // Works out the recoloured pixel and the source HSL for one input beat.
    static function rhr_pkg::pix_out_t recolour(rhr_pkg::pix_in_t p);
      rhr_pkg::pix_out_t o;
      longint r, g, b, nh, mx, mn, d, sum, h, s, l, hn, v, m, ro, go, bo, num;
      longint sv, h6, sext, fr, vsf, mid1, mid2;
      r = p.in_red; g = p.in_green; b = p.in_blue; nh = p.new_hue;
      h = 0; s = 0;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      l = (sum * ONE_FX) / 510;
      if (d != 0) begin
        if (sum < 255) s = (d * ONE_FX) / sum;
        else s = (d * ONE_FX) / (510 - sum);
        if (r == mx) num = g - b;
        else if (g == mx) num = 2 * d + (b - r);
        else num = 4 * d + (r - g);
        if (num < 0) num += 6 * d;
        h = (num * ONE_FX) / (6 * d);
      end
      hn = (nh << FB) >>> 16;
      ro = l; go = l; bo = l;
      if (l <= HALF_FX) v = (l * (ONE_FX + s)) >>> FB;
      else v = l + s - ((l * s) >>> FB);
      if (v > 0) begin
        m = 2 * l - v;
        if (m < 0) m = 0;
        sv = ((v - m) * ONE_FX) / v;
        h6 = hn * 6;
        sext = h6 >>> FB;
        fr = h6 & (ONE_FX - 1);
        vsf = (((v * sv) >>> FB) * fr) >>> FB;
        mid1 = m + vsf;
        mid2 = v - vsf;
        case (sext)
          0: begin ro = v; go = mid1; bo = m; end
          1: begin ro = mid2; go = v; bo = m; end
          2: begin ro = m; go = v; bo = mid1; end
          3: begin ro = m; go = mid2; bo = v; end
          4: begin ro = mid1; go = m; bo = v; end
          default: begin ro = v; go = m; bo = mid2; end
        endcase
      end
      o.out_red = 8'(to_byte(ro));
      o.out_green = 8'(to_byte(go));
      o.out_blue = 8'(to_byte(bo));
      o.src_hue = to_q16(h);
      o.src_saturation = to_q16(s);
      o.src_lightness = to_q16(l);
      return o;
    endfunction

    function void note_pixel(rhr_pkg::pix_in_t p);
      pending.push_back(recolour(p));
    endfunction

    function void check_result(rhr_pkg::pix_out_t act);
      rhr_pkg::pix_out_t exp_px;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", act);
        return;
      end
      exp_px = pending.pop_front();
      if (act !== exp_px) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch at result %0d: expected %p, got %p", checked, exp_px, act);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rhr_pkg::pix_in_t in_i = '0;
  logic done_o;
  rhr_pkg::pix_out_t res_o;

  pixel_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  rgb_hsl_hue_recolor_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .done_o(done_o), .res_o(res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Results are sampled at the edge, before the driver's nonblocking updates land.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
    if (rst_ni && ((start && !busy) || done_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Presents one beat and holds it until accepted; start stays high when the next beat follows.
  task automatic send_pixel(rhr_pkg::pix_in_t p, int unsigned gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= p;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(p);
    sent++;
  endtask

  function automatic rhr_pkg::pix_in_t rand_pixel();
    rhr_pkg::pix_in_t p;
    int unsigned k;
    p = rhr_pkg::pix_in_t'(40'({$urandom, $urandom}));
    k = $urandom_range(0, 9);
    // Greys, ties and extremes get extra weight.
    if (k == 0) begin p.in_green = p.in_red; p.in_blue = p.in_red; end
    else if (k == 1) p.in_green = p.in_red;
    else if (k == 2) p.in_blue = p.in_green;
    else if (k == 3) p.in_red = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    else if (k == 4) p.new_hue = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return p;
  endfunction

  initial begin
    rhr_pkg::pix_in_t dir[$];
    rhr_pkg::pix_in_t p;
    int unsigned waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir.push_back('{8'd0, 8'd0, 8'd0, 16'd0});          // black
    dir.push_back('{8'd255, 8'd255, 8'd255, 16'hFFFF}); // white
    dir.push_back('{8'd128, 8'd128, 8'd128, 16'h4000}); // grey
    dir.push_back('{8'd255, 8'd0, 8'd0, 16'h2AAA});
    dir.push_back('{8'd0, 8'd255, 8'd0, 16'h5555});
    dir.push_back('{8'd0, 8'd0, 8'd255, 16'h8000});
    dir.push_back('{8'd255, 8'd255, 8'd0, 16'hAAAA});   // red and green tie
    dir.push_back('{8'd0, 8'd200, 8'd200, 16'hD555});   // green and blue tie
    dir.push_back('{8'd200, 8'd10, 8'd200, 16'hFFFF});
    dir.push_back('{8'd127, 8'd127, 8'd0, 16'h1234});   // sum below half
    dir.push_back('{8'd128, 8'd127, 8'd127, 16'h1234}); // sum at half
    dir.push_back('{8'd255, 8'd254, 8'd254, 16'h7FFF});
    dir.push_back('{8'd1, 8'd0, 8'd0, 16'hC000});
    dir.push_back('{8'd10, 8'd50, 8'd30, 16'h0001});
    dir.push_back('{8'd30, 8'd50, 8'd90, 16'hFFFE});
    dir.push_back('{8'd90, 8'd20, 8'd60, 16'h9999});
    dir.push_back('{8'd255, 8'd0, 8'd255, 16'h0000});
    dir.push_back('{8'hAA, 8'h55, 8'hAA, 16'hAAAA});
    dir.push_back('{8'h55, 8'hAA, 8'h55, 16'h5555});
    foreach (dir[i]) send_pixel(dir[i], (i % 3 == 0) ? 0 : i % 4);

    repeat (1100) begin
      p = rand_pixel();
      send_pixel(p, ($urandom_range(0, 5) == 0) ? 0 : pick_gap());
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d pixels (directed extremes, greys, ties, random hues); checked %0d results.",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
